/* src/buh_pkg.sv */
// ----------------------------------------------------------------------------
// buh_pkg
// Shared sizes, codes and beat types for the bounded undo/redo history.
// ----------------------------------------------------------------------------
package buh_pkg;

  // ring and record geometry
  localparam int SLOTS   = 16;
  localparam int WORDS   = 5;
  localparam int WORD_W  = 32;
  localparam int IDX_W   = $clog2(SLOTS);
  localparam int STORE_D = SLOTS * WORDS;
  localparam int ADDR_W  = $clog2(STORE_D);
  localparam int WIDX_W  = $clog2(WORDS);
  localparam int STEP_W  = $clog2(WORDS + 1);

  // field widths fixed by the interface
  localparam int KIND_W   = 2;
  localparam int STATUS_W = 3;
  localparam int DEPTH_W  = 4;

  // item kinds
  localparam logic [KIND_W-1:0] KIND_SET  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_UNDO = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REDO = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_APPLIED    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FIRST      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_SAME       = 3'd2;
  localparam logic [STATUS_W-1:0] ST_UNDO_EMPTY = 3'd3;
  localparam logic [STATUS_W-1:0] ST_REDO_EMPTY = 3'd4;

  // command beat
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [WORD_W-1:0] new_pos_0;
    logic [WORD_W-1:0] new_pos_1;
    logic [WORD_W-1:0] new_pos_2;
    logic [WORD_W-1:0] new_pos_3;
    logic [WORD_W-1:0] new_pos_4;
  } cmd_t;

  // result beat
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                have_current;
    logic [WORD_W-1:0]   cur_pos_0;
    logic [WORD_W-1:0]   cur_pos_1;
    logic [WORD_W-1:0]   cur_pos_2;
    logic [WORD_W-1:0]   cur_pos_3;
    logic [WORD_W-1:0]   cur_pos_4;
    logic [DEPTH_W-1:0]  undo_depth;
    logic [DEPTH_W-1:0]  redo_depth;
  } result_t;

endpackage

/* src/buh_ram.sv */
// ----------------------------------------------------------------------------
// buh_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module buh_ram #(
  parameter  int WIDTH = 32,
  parameter  int DEPTH = 80,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/bounded_undo_redo_history.sv */
// ----------------------------------------------------------------------------
// bounded_undo_redo_history
// Current record of five words with bounded undo and redo ring stacks.
// ----------------------------------------------------------------------------
// A command beat is taken when start is high and busy is low. A first set, an
// empty undo or redo and an unknown kind are finished from the idle state and
// never raise busy; any other item holds busy high until it is finished. The
// result beat appears on result for exactly one cycle with done high. Busy is
// already low in that cycle, so the next command beat can be taken at the edge
// that ends it. The receiver cannot stall the result. A set equal to the
// current record takes five word compares; a set that is applied takes five
// compares through the single shared float-equality unit and five word writes
// through the undo store write port; an undo or redo takes five word reads
// through the one store read port and its registered read, with the current
// record written to the other store in the same cycles. The stores need no
// clearing after reset.
// ----------------------------------------------------------------------------
module bounded_undo_redo_history (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  buh_pkg::cmd_t    cmd,
  output logic             busy,
  output logic             done,
  output buh_pkg::result_t result
);
  import buh_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_PUSH,
    S_XFER
  } state_t;

  state_t              state;
  logic [KIND_W-1:0]   kind_r;
  logic [STEP_W-1:0]   step;
  logic                same;
  logic [STATUS_W-1:0] status_r;
  logic                loaded;
  logic [WORD_W-1:0]   current [WORDS];
  logic [WORD_W-1:0]   nw      [WORDS];
  logic [IDX_W-1:0]    undo_head;
  logic [IDX_W-1:0]    undo_tail;
  logic [IDX_W-1:0]    redo_head;
  logic [IDX_W-1:0]    redo_tail;

  logic                undo_we;
  logic                redo_we;
  logic [ADDR_W-1:0]   undo_waddr;
  logic [ADDR_W-1:0]   redo_waddr;
  logic [ADDR_W-1:0]   undo_raddr;
  logic [ADDR_W-1:0]   redo_raddr;
  logic [WORD_W-1:0]   undo_rdata;
  logic [WORD_W-1:0]   redo_rdata;
  logic [WORD_W-1:0]   src_rdata;
  logic [WIDX_W-1:0]   cur_widx;
  logic [WIDX_W-1:0]   rd_widx;
  logic [WORD_W-1:0]   cur_word;
  logic                word_eq;
  logic                last_word;

  // ring helpers
  function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] i);
    return (i == IDX_W'(SLOTS - 1)) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [IDX_W-1:0] ring_prev(input logic [IDX_W-1:0] i);
    return (i == '0) ? IDX_W'(SLOTS - 1) : i - 1'b1;
  endfunction

  function automatic logic [DEPTH_W-1:0] ring_depth(input logic [IDX_W-1:0] h,
                                                    input logic [IDX_W-1:0] t);
    logic [IDX_W:0] d;
    d = {1'b0, h} + (IDX_W + 1)'(SLOTS) - {1'b0, t};
    if (d >= (IDX_W + 1)'(SLOTS)) begin
      d = d - (IDX_W + 1)'(SLOTS);
    end
    return DEPTH_W'(d);
  endfunction

  function automatic logic [ADDR_W-1:0] slot_addr(input logic [IDX_W-1:0]  s,
                                                  input logic [WIDX_W-1:0] w);
    return ADDR_W'(s) * ADDR_W'(WORDS) + ADDR_W'(w);
  endfunction

  // ieee single equality: nan never equal, signed zeros equal
  function automatic logic fp_equal(input logic [WORD_W-1:0] a,
                                    input logic [WORD_W-1:0] b);
    logic a_nan;
    logic b_nan;
    a_nan = (a[30:23] == 8'hFF) && (a[22:0] != '0);
    b_nan = (b[30:23] == 8'hFF) && (b[22:0] != '0);
    if (a_nan || b_nan) begin
      return 1'b0;
    end
    if ((a[30:0] | b[30:0]) == '0) begin
      return 1'b1;
    end
    return a == b;
  endfunction

  // shared word index and compare unit
  assign cur_widx  = (state == S_XFER) ? WIDX_W'(step - 1'b1) : step[WIDX_W-1:0];
  assign rd_widx   = (step == STEP_W'(WORDS)) ? '0 : step[WIDX_W-1:0];
  assign cur_word  = current[cur_widx];
  assign word_eq   = fp_equal(cur_word, nw[cur_widx]);
  assign last_word = (step == STEP_W'(WORDS - 1));
  assign src_rdata = (kind_r == KIND_UNDO) ? undo_rdata : redo_rdata;

  // store port control
  always_comb begin
    undo_we    = (state == S_PUSH) ||
                 ((state == S_XFER) && (kind_r == KIND_REDO) && (step != '0));
    redo_we    = (state == S_XFER) && (kind_r == KIND_UNDO) && (step != '0);
    undo_waddr = slot_addr(ring_next(undo_head), cur_widx);
    redo_waddr = slot_addr(ring_next(redo_head), cur_widx);
    undo_raddr = slot_addr(undo_head, rd_widx);
    redo_raddr = slot_addr(redo_head, rd_widx);
  end

  buh_ram #(
    .WIDTH (WORD_W),
    .DEPTH (STORE_D)
  ) u_undo_store (
    .clk   (clk),
    .we    (undo_we),
    .waddr (undo_waddr),
    .wdata (cur_word),
    .raddr (undo_raddr),
    .rdata (undo_rdata)
  );

  buh_ram #(
    .WIDTH (WORD_W),
    .DEPTH (STORE_D)
  ) u_redo_store (
    .clk   (clk),
    .we    (redo_we),
    .waddr (redo_waddr),
    .wdata (cur_word),
    .raddr (redo_raddr),
    .rdata (redo_rdata)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      done      <= 1'b0;
      loaded    <= 1'b0;
      undo_head <= '0;
      undo_tail <= '0;
      redo_head <= '0;
      redo_tail <= '0;
      step      <= '0;
      same      <= 1'b0;
      kind_r    <= KIND_SET;
      status_r  <= ST_SAME;
      for (int i = 0; i < WORDS; i++) begin
        current[i] <= '0;
      end
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            kind_r <= cmd.kind;
            step   <= '0;
            same   <= 1'b1;
            nw[0]  <= cmd.new_pos_0;
            nw[1]  <= cmd.new_pos_1;
            nw[2]  <= cmd.new_pos_2;
            nw[3]  <= cmd.new_pos_3;
            nw[4]  <= cmd.new_pos_4;
            unique case (cmd.kind)
              KIND_SET: begin
                if (!loaded) begin
                  current[0] <= cmd.new_pos_0;
                  current[1] <= cmd.new_pos_1;
                  current[2] <= cmd.new_pos_2;
                  current[3] <= cmd.new_pos_3;
                  current[4] <= cmd.new_pos_4;
                  loaded     <= 1'b1;
                  status_r   <= ST_FIRST;
                  done       <= 1'b1;
                end else begin
                  state <= S_CMP;
                end
              end
              KIND_UNDO: begin
                if (undo_head == undo_tail) begin
                  status_r <= ST_UNDO_EMPTY;
                  done     <= 1'b1;
                end else begin
                  state <= S_XFER;
                end
              end
              KIND_REDO: begin
                if (redo_head == redo_tail) begin
                  status_r <= ST_REDO_EMPTY;
                  done     <= 1'b1;
                end else begin
                  state <= S_XFER;
                end
              end
              default: begin
                status_r <= ST_SAME;
                done     <= 1'b1;
              end
            endcase
          end
        end
        // one word compared per cycle
        S_CMP: begin
          if (!word_eq) begin
            same <= 1'b0;
          end
          if (last_word) begin
            if (same && word_eq) begin
              status_r <= ST_SAME;
              done     <= 1'b1;
              state    <= S_IDLE;
            end else begin
              redo_head <= '0;
              redo_tail <= '0;
              step      <= '0;
              state     <= S_PUSH;
            end
          end else begin
            step <= step + 1'b1;
          end
        end
        // current record written to undo one word per cycle
        S_PUSH: begin
          if (last_word) begin
            if (ring_next(undo_head) == undo_tail) begin
              undo_tail <= ring_next(undo_tail);
            end
            undo_head <= ring_next(undo_head);
            for (int i = 0; i < WORDS; i++) begin
              current[i] <= nw[i];
            end
            status_r <= ST_APPLIED;
            done     <= 1'b1;
            state    <= S_IDLE;
          end else begin
            step <= step + 1'b1;
          end
        end
        // pop one ring into current while current goes to the other ring
        S_XFER: begin
          if (step != '0) begin
            current[cur_widx] <= src_rdata;
          end
          if (step == STEP_W'(WORDS)) begin
            if (kind_r == KIND_UNDO) begin
              undo_head <= ring_prev(undo_head);
              if (ring_next(redo_head) == redo_tail) begin
                redo_tail <= ring_next(redo_tail);
              end
              redo_head <= ring_next(redo_head);
            end else begin
              redo_head <= ring_prev(redo_head);
              if (ring_next(undo_head) == undo_tail) begin
                undo_tail <= ring_next(undo_tail);
              end
              undo_head <= ring_next(undo_head);
            end
            status_r <= ST_APPLIED;
            done     <= 1'b1;
            state    <= S_IDLE;
          end else begin
            step <= step + 1'b1;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign busy = (state != S_IDLE);

  // result beat from held state
  always_comb begin
    result.status       = status_r;
    result.have_current = loaded;
    result.cur_pos_0    = current[0];
    result.cur_pos_1    = current[1];
    result.cur_pos_2    = current[2];
    result.cur_pos_3    = current[3];
    result.cur_pos_4    = current[4];
    result.undo_depth   = ring_depth(undo_head, undo_tail);
    result.redo_depth   = ring_depth(redo_head, redo_tail);
  end

endmodule

/* tb/sv/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the bounded undo/redo history. A directed table
// covers empty pops, first load, float-equality corner cases and unknown
// kinds; random runs of sets, undos and redos then fill and overflow both
// rings. Every result beat is checked field by field against the table's
// expected beat or a local model of the history.
// ----------------------------------------------------------------------------
module tb;
  import buh_pkg::*;

  // bench constants
  localparam int IDLE_LIMIT    = 200;
  localparam int RANDOM_ITEMS  = 1150;
  localparam int MAX_REPORTS   = 40;
  localparam int TAIL_CYCLES   = 20;
  localparam int UNDO_RING     = 0;
  localparam int REDO_RING     = 1;
  localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;

  typedef logic [WORDS-1:0][WORD_W-1:0] record_t;
  typedef enum int {RUN_SET, RUN_UNDO, RUN_REDO, RUN_MIXED} run_t;
  typedef struct {
    cmd_t    beat;
    bit      typed;
    result_t want;
  } row_t;

  // records for the directed table, word 4 first
  localparam record_t REC_ZERO = '0;
  localparam record_t REC_ONES = '1;
  localparam record_t REC_A = {32'h7FFFFFFF, 32'h7F800000, 32'h80000000,
                               32'hFFFFFFFF, 32'h00000000};
  localparam record_t REC_B = {32'h00000001, 32'h7F7FFFFF, 32'hFF800000,
                               32'h00000000, 32'h80000000};
  localparam record_t REC_B_ZSWAP = {32'h00000001, 32'h7F7FFFFF, 32'hFF800000,
                                     32'h80000000, 32'h00000000};
  localparam record_t REC_C = {32'h807FFFFF, 32'h00800000, 32'h3F800000,
                               32'hFF800001, 32'h7FC00000};
  localparam record_t REC_D = {32'h80000000, 32'h00000000, 32'h3F800000,
                               32'hFF800000, 32'h7F800000};
  localparam record_t REC_D_BIT = {32'h80000001, 32'h00000000, 32'h3F800000,
                                   32'hFF800000, 32'h7F800000};

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    start = 1'b0;
  cmd_t    cmd = '0;
  logic    busy;
  logic    done;
  result_t result;

  bounded_undo_redo_history DUT (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done),
    .result (result)
  );

  always #1 clk = ~clk;

  // history model state
  record_t hist_cur;
  bit      hist_loaded;
  record_t ring_mem [2][SLOTS];
  int      ring_head [2];
  int      ring_tail [2];

  result_t pending_results [$];
  row_t    steps [$];
  int      errors;
  int      idle_cycles;
  int      burst_left;

  // float equality: nan never equal, signed zeros equal
  function automatic bit is_nan(input logic [WORD_W-1:0] w);
    return w[30:0] > 31'h7F800000;
  endfunction

  function automatic bit words_equal(input logic [WORD_W-1:0] a, input logic [WORD_W-1:0] b);
    if (is_nan(a) || is_nan(b)) return 1'b0;
    if ((a[30:0] | b[30:0]) == 31'd0) return 1'b1;
    return a == b;
  endfunction

  function automatic logic [DEPTH_W-1:0] ring_depth(input int r);
    return DEPTH_W'((ring_head[r] + SLOTS - ring_tail[r]) % SLOTS);
  endfunction

  // push drops the oldest record when the ring is full
  function automatic void ring_push(input int r, input record_t rec);
    int nh;
    nh = (ring_head[r] + 1) % SLOTS;
    if (nh == ring_tail[r]) ring_tail[r] = (ring_tail[r] + 1) % SLOTS;
    ring_head[r] = nh;
    ring_mem[r][nh] = rec;
  endfunction

  function automatic record_t ring_pop(input int r);
    record_t rec;
    rec = ring_mem[r][ring_head[r]];
    ring_head[r] = (ring_head[r] + SLOTS - 1) % SLOTS;
    return rec;
  endfunction

  function automatic cmd_t mk_beat(input logic [KIND_W-1:0] kind, input record_t rec);
    cmd_t c;
    c.kind      = kind;
    c.new_pos_0 = rec[0];
    c.new_pos_1 = rec[1];
    c.new_pos_2 = rec[2];
    c.new_pos_3 = rec[3];
    c.new_pos_4 = rec[4];
    return c;
  endfunction

  function automatic result_t mk_res(input logic [STATUS_W-1:0] st, input logic have,
                                     input record_t rec, input logic [DEPTH_W-1:0] ud,
                                     input logic [DEPTH_W-1:0] rd);
    result_t r;
    r.status       = st;
    r.have_current = have;
    r.cur_pos_0    = rec[0];
    r.cur_pos_1    = rec[1];
    r.cur_pos_2    = rec[2];
    r.cur_pos_3    = rec[3];
    r.cur_pos_4    = rec[4];
    r.undo_depth   = ud;
    r.redo_depth   = rd;
    return r;
  endfunction

  // move from one ring to current, current onto the other ring
  function automatic void swap_through(input int from_r, input int to_r);
    record_t popped;
    popped = ring_pop(from_r);
    ring_push(to_r, hist_cur);
    hist_cur = popped;
  endfunction

  // advance the history by one command beat and return its result beat
  function automatic result_t apply_history(input cmd_t c);
    record_t             nw;
    logic [STATUS_W-1:0] st;
    bit                  same;
    int                  i;
    nw = {c.new_pos_4, c.new_pos_3, c.new_pos_2, c.new_pos_1, c.new_pos_0};
    st = ST_SAME;
    case (c.kind)
      KIND_SET: begin
        if (!hist_loaded) begin
          hist_cur    = nw;
          hist_loaded = 1'b1;
          st          = ST_FIRST;
        end else begin
          same = 1'b1;
          for (i = 0; i < WORDS; i++)
            if (!words_equal(hist_cur[i], nw[i])) same = 1'b0;
          if (!same) begin
            ring_head[REDO_RING] = 0;
            ring_tail[REDO_RING] = 0;
            ring_push(UNDO_RING, hist_cur);
            hist_cur = nw;
            st       = ST_APPLIED;
          end
        end
      end
      KIND_UNDO: begin
        if (ring_head[UNDO_RING] == ring_tail[UNDO_RING]) begin
          st = ST_UNDO_EMPTY;
        end else begin
          swap_through(UNDO_RING, REDO_RING);
          st = ST_APPLIED;
        end
      end
      KIND_REDO: begin
        if (ring_head[REDO_RING] == ring_tail[REDO_RING]) begin
          st = ST_REDO_EMPTY;
        end else begin
          swap_through(REDO_RING, UNDO_RING);
          st = ST_APPLIED;
        end
      end
      default: st = ST_SAME;
    endcase
    return mk_res(st, hist_loaded, hist_cur, ring_depth(UNDO_RING), ring_depth(REDO_RING));
  endfunction

  // random words lean on float corner values
  function automatic logic [WORD_W-1:0] rand_word();
    case ($urandom_range(0, 9))
      0: return 32'h00000000;
      1: return 32'h80000000;
      2: return 32'h7F800000;
      3: return 32'hFF800000;
      4: return {$urandom_range(0, 1) == 1, 8'hFF, 23'($urandom_range(1, 23'h7FFFFF))};
      5: return 32'h3F800000;
      default: return $urandom;
    endcase
  endfunction

  function automatic record_t rand_record();
    record_t rec;
    int      i;
    for (i = 0; i < WORDS; i++) rec[i] = rand_word();
    return rec;
  endfunction

  // set records: half new, the rest equal or nearly equal to current
  function automatic record_t next_set_record();
    record_t rec;
    int      i;
    rec = hist_cur;
    case ($urandom_range(0, 9))
      0, 1: ;
      2: begin
        for (i = 0; i < WORDS; i++)
          if (rec[i][30:0] == 31'd0) rec[i][31] = 1'($urandom_range(0, 1));
      end
      3: rec[$urandom_range(0, WORDS - 1)] = rand_word();
      4: rec[$urandom_range(0, WORDS - 1)][$urandom_range(0, WORD_W - 1)] ^= 1'b1;
      default: rec = rand_record();
    endcase
    return rec;
  endfunction

  task automatic add_row(input logic [KIND_W-1:0] kind, input record_t rec, input bit typed,
                         input result_t want);
    row_t row;
    row.beat  = mk_beat(kind, rec);
    row.typed = typed;
    row.want  = want;
    steps.push_back(row);
  endtask

  // offer one command beat, then maybe close the burst with a gap
  task automatic send_item(input cmd_t c, input bit typed, input result_t want);
    result_t predicted;
    start <= 1'b1;
    cmd   <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
    predicted = apply_history(c);
    pending_results.push_back(typed ? want : predicted);
    burst_left--;
    if (burst_left <= 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
    end
  endtask

  // hold off until every result beat has come back
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic field_check(input string name, input logic [WORD_W-1:0] want,
                             input logic [WORD_W-1:0] got);
    if (got !== want) begin
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t: mismatch on %s, expected %h, actual %h", $time, name, want, got);
    end
  endtask

  // result beats are taken on every edge with done high
  always @(posedge clk) begin
    result_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: result beat with nothing expected, expected none, actual %h",
                   $time, result);
      end else begin
        want = pending_results.pop_front();
        field_check("status", want.status, result.status);
        field_check("have_current", want.have_current, result.have_current);
        field_check("cur_pos_0", want.cur_pos_0, result.cur_pos_0);
        field_check("cur_pos_1", want.cur_pos_1, result.cur_pos_1);
        field_check("cur_pos_2", want.cur_pos_2, result.cur_pos_2);
        field_check("cur_pos_3", want.cur_pos_3, result.cur_pos_3);
        field_check("cur_pos_4", want.cur_pos_4, result.cur_pos_4);
        field_check("undo_depth", want.undo_depth, result.undo_depth);
        field_check("redo_depth", want.redo_depth, result.redo_depth);
      end
    end
  end

  // watchdog on cycles with no beat in either direction
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no beat for %0d cycles", $time, idle_cycles);
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    run_t run;
    int   run_len;
    int   items_done;
    int   j;
    cmd_t c;

    errors      = 0;
    idle_cycles = 0;
    burst_left  = $urandom_range(1, 12);
    hist_cur    = '0;
    hist_loaded = 1'b0;
    ring_head   = '{0, 0};
    ring_tail   = '{0, 0};

    // directed table: empty pops, first load, unknown kinds, nan and signed-zero equality
    add_row(KIND_UNDO, REC_ZERO, 1'b1, mk_res(ST_UNDO_EMPTY, 1'b0, REC_ZERO, '0, '0));
    add_row(KIND_REDO, REC_ZERO, 1'b1, mk_res(ST_REDO_EMPTY, 1'b0, REC_ZERO, '0, '0));
    add_row(KIND_NONE, REC_A, 1'b1, mk_res(ST_SAME, 1'b0, REC_ZERO, '0, '0));
    add_row(KIND_SET, REC_A, 1'b1, mk_res(ST_FIRST, 1'b1, REC_A, '0, '0));
    add_row(KIND_SET, REC_A, 1'b1, mk_res(ST_APPLIED, 1'b1, REC_A, 4'd1, '0));
    add_row(KIND_SET, REC_B, 1'b1, mk_res(ST_APPLIED, 1'b1, REC_B, 4'd2, '0));
    add_row(KIND_SET, REC_B_ZSWAP, 1'b1, mk_res(ST_SAME, 1'b1, REC_B, 4'd2, '0));
    add_row(KIND_NONE, REC_ONES, 1'b1, mk_res(ST_SAME, 1'b1, REC_B, 4'd2, '0));
    add_row(KIND_UNDO, REC_ONES, 1'b0, '0);
    add_row(KIND_UNDO, REC_ZERO, 1'b0, '0);
    add_row(KIND_UNDO, REC_ZERO, 1'b0, '0);
    add_row(KIND_REDO, REC_ZERO, 1'b0, '0);
    add_row(KIND_REDO, REC_ONES, 1'b0, '0);
    add_row(KIND_REDO, REC_ZERO, 1'b0, '0);
    add_row(KIND_UNDO, REC_ZERO, 1'b0, '0);
    add_row(KIND_SET, REC_C, 1'b0, '0);
    add_row(KIND_SET, REC_C, 1'b0, '0);
    add_row(KIND_SET, REC_D, 1'b0, '0);
    add_row(KIND_SET, REC_D, 1'b0, '0);
    add_row(KIND_SET, REC_D_BIT, 1'b0, '0);
    add_row(KIND_UNDO, REC_ZERO, 1'b0, '0);
    add_row(KIND_REDO, REC_ZERO, 1'b0, '0);
    add_row(KIND_SET, REC_ZERO, 1'b0, '0);
    add_row(KIND_SET, REC_ONES, 1'b0, '0);

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (steps[k]) send_item(steps[k].beat, steps[k].typed, steps[k].want);
    drain();

    // random runs that fill, overflow and empty both rings
    items_done = 0;
    while (items_done < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: run = RUN_SET;
        4, 5:       run = RUN_UNDO;
        6, 7:       run = RUN_REDO;
        default:    run = RUN_MIXED;
      endcase
      run_len = (run == RUN_MIXED) ? $urandom_range(1, 6) : $urandom_range(1, 20);
      for (j = 0; j < run_len; j++) begin
        case (run)
          RUN_SET:  c = mk_beat(KIND_SET, next_set_record());
          RUN_UNDO: c = mk_beat(KIND_UNDO, rand_record());
          RUN_REDO: c = mk_beat(KIND_REDO, rand_record());
          default:  c = mk_beat(KIND_W'($urandom_range(0, 3)), rand_record());
        endcase
        send_item(c, 1'b0, '0);
        if (c.kind != KIND_NONE) items_done++;
        if ($urandom_range(0, 299) == 0) drain();
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
